### rtl/core/clni_pkg.sv
// Shared types, command codes and control store for the 4-bit LCD interface unit.
package clni_pkg;

  // Request command codes
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_INSTR = 3'd1;
  localparam logic [2:0] CMD_DATA  = 3'd2;
  localparam logic [2:0] CMD_GOTO  = 3'd3;
  localparam logic [2:0] CMD_GLYPH = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE_HIGH = 2'd0;
  localparam logic [1:0] REG_ENABLE_GAP  = 2'd1;
  localparam logic [1:0] REG_WRITE_WAIT  = 2'd2;
  localparam logic [1:0] REG_GOTO_WAIT   = 2'd3;

  // Register reset values
  localparam logic [9:0]  ENABLE_HIGH_RST = 10'd10;
  localparam logic [9:0]  ENABLE_GAP_RST  = 10'd50;
  localparam logic [15:0] WRITE_WAIT_RST  = 16'd10000;
  localparam logic [15:0] GOTO_WAIT_RST   = 16'd1000;

  // Fixed init waits
  localparam logic [15:0] POWER_UP_US = 16'd15000;
  localparam logic [15:0] WAKE_LONG_US = 16'd5000;
  localparam logic [15:0] WAKE_SHORT_US = 16'd160;

  // Row base addresses and glyph codes
  localparam logic [1:0] DDRAM_SET_MSB = 2'b10;    // 0x80 / 0xC0 prefix
  localparam logic [1:0] CGRAM_SET_MSB = 2'b01;    // 0x40 prefix
  localparam logic [7:0] GLYPH_DONE_BYTE = 8'h80;

  // Control store layout
  localparam int unsigned ROM_DEPTH = 38;
  localparam int unsigned PC_W = $clog2(ROM_DEPTH);
  localparam logic [PC_W-1:0] INIT_ENTRY = PC_W'(0);
  localparam logic [PC_W-1:0] BYTE_ENTRY = PC_W'(32);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HI,
    NIB_LO
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_EN_HIGH,
    HOLD_EN_GAP,
    HOLD_WRITE,
    HOLD_GOTO,
    HOLD_POWER_UP,
    HOLD_WAKE_LONG,
    HOLD_WAKE_SHORT
  } hold_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_END,
    SEQ_END_UNLESS_GOTO
  } seq_t;

  typedef struct packed {
    logic      en;
    nib_sel_t  nib_sel;
    logic [3:0] nib;
    hold_sel_t hold_sel;
    seq_t      seq;
  } ucode_t;

  function automatic ucode_t uw(logic en, nib_sel_t ns, logic [3:0] nib,
                                hold_sel_t hs, seq_t sq);
    ucode_t w;
    w.en       = en;
    w.nib_sel  = ns;
    w.nib      = nib;
    w.hold_sel = hs;
    w.seq      = sq;
    return w;
  endfunction

  // Control store: init program at 0, shared byte write at 32, goto tail at 37
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      // power-up wait, then wake-up nibbles 3,3,3,2
      6'd0:  w = uw(1'b0, NIB_CONST, 4'h0, HOLD_POWER_UP,   SEQ_NEXT);
      6'd1:  w = uw(1'b1, NIB_CONST, 4'h3, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd2:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_EN_GAP,     SEQ_NEXT);
      6'd3:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_WAKE_LONG,  SEQ_NEXT);
      6'd4:  w = uw(1'b1, NIB_CONST, 4'h3, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd5:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_EN_GAP,     SEQ_NEXT);
      6'd6:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_WAKE_SHORT, SEQ_NEXT);
      6'd7:  w = uw(1'b1, NIB_CONST, 4'h3, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd8:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_EN_GAP,     SEQ_NEXT);
      6'd9:  w = uw(1'b0, NIB_CONST, 4'h3, HOLD_WAKE_SHORT, SEQ_NEXT);
      6'd10: w = uw(1'b1, NIB_CONST, 4'h2, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd11: w = uw(1'b0, NIB_CONST, 4'h2, HOLD_EN_GAP,     SEQ_NEXT);
      // function set 0x28
      6'd12: w = uw(1'b1, NIB_CONST, 4'h2, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd13: w = uw(1'b0, NIB_CONST, 4'h2, HOLD_EN_GAP,     SEQ_NEXT);
      6'd14: w = uw(1'b1, NIB_CONST, 4'h8, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd15: w = uw(1'b0, NIB_CONST, 4'h8, HOLD_EN_GAP,     SEQ_NEXT);
      6'd16: w = uw(1'b0, NIB_CONST, 4'h8, HOLD_WRITE,      SEQ_NEXT);
      // display on 0x0C
      6'd17: w = uw(1'b1, NIB_CONST, 4'h0, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd18: w = uw(1'b0, NIB_CONST, 4'h0, HOLD_EN_GAP,     SEQ_NEXT);
      6'd19: w = uw(1'b1, NIB_CONST, 4'hC, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd20: w = uw(1'b0, NIB_CONST, 4'hC, HOLD_EN_GAP,     SEQ_NEXT);
      6'd21: w = uw(1'b0, NIB_CONST, 4'hC, HOLD_WRITE,      SEQ_NEXT);
      // clear 0x01
      6'd22: w = uw(1'b1, NIB_CONST, 4'h0, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd23: w = uw(1'b0, NIB_CONST, 4'h0, HOLD_EN_GAP,     SEQ_NEXT);
      6'd24: w = uw(1'b1, NIB_CONST, 4'h1, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd25: w = uw(1'b0, NIB_CONST, 4'h1, HOLD_EN_GAP,     SEQ_NEXT);
      6'd26: w = uw(1'b0, NIB_CONST, 4'h1, HOLD_WRITE,      SEQ_NEXT);
      // entry mode 0x06
      6'd27: w = uw(1'b1, NIB_CONST, 4'h0, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd28: w = uw(1'b0, NIB_CONST, 4'h0, HOLD_EN_GAP,     SEQ_NEXT);
      6'd29: w = uw(1'b1, NIB_CONST, 4'h6, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd30: w = uw(1'b0, NIB_CONST, 4'h6, HOLD_EN_GAP,     SEQ_NEXT);
      6'd31: w = uw(1'b0, NIB_CONST, 4'h6, HOLD_WRITE,      SEQ_END);
      // request byte, both nibbles and settle
      6'd32: w = uw(1'b1, NIB_HI,    4'h0, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd33: w = uw(1'b0, NIB_HI,    4'h0, HOLD_EN_GAP,     SEQ_NEXT);
      6'd34: w = uw(1'b1, NIB_LO,    4'h0, HOLD_EN_HIGH,    SEQ_NEXT);
      6'd35: w = uw(1'b0, NIB_LO,    4'h0, HOLD_EN_GAP,     SEQ_NEXT);
      6'd36: w = uw(1'b0, NIB_LO,    4'h0, HOLD_WRITE,      SEQ_END_UNLESS_GOTO);
      // goto extra wait
      6'd37: w = uw(1'b0, NIB_LO,    4'h0, HOLD_GOTO,       SEQ_END);
      default: w = uw(1'b0, NIB_LO,  4'h0, HOLD_GOTO,       SEQ_END);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/clni_if.sv
// Request and pin-state channel interfaces for the LCD interface unit.
interface clni_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] byte_value;
  logic [5:0] column;
  logic       row;
  logic [3:0] glyph_slot;

  modport source (output valid, command, byte_value, column, row, glyph_slot,
                  input ready);
  modport sink   (input valid, command, byte_value, column, row, glyph_slot,
                  output ready);
endinterface

interface clni_pin_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable_pin;
  logic [3:0]  bus_nibble;
  logic [15:0] hold_us;
  logic        last;

  modport source (output valid, reg_select, enable_pin, bus_nibble, hold_us, last,
                  input ready);
  modport sink   (input valid, reg_select, enable_pin, bus_nibble, hold_us, last,
                  output ready);
endinterface

### rtl/core/char_lcd_nibble_interface_unit.sv
// Top level: microcoded 4-bit character LCD pin sequencer.
// Acceptance latches the request into the sequencer; its first control word then issues a pin-state beat.
// Throughput: one pin-state beat per cycle while the sink is ready; each beat issues one
// control word, so init runs 32 control words, a byte or glyph 5 and a goto 6.
// A new request is taken once the last control word of the current one has issued.
// Reset (synchronous, rst high): sequencer idle, no beat pending, registers to defaults.
module char_lcd_nibble_interface_unit (
  input  logic              clk,
  input  logic              rst,
  clni_req_if.sink          req,
  clni_pin_if.source        pins,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import clni_pkg::*;

  // configuration registers
  logic [9:0]  enable_high_us;
  logic [9:0]  enable_gap_us;
  logic [15:0] write_wait_us;
  logic [15:0] goto_wait_us;

  // sequencer state
  logic       busy;
  pc_t        pc;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic       is_goto;

  // output register
  logic        out_valid;
  logic        out_rs;
  logic        out_en;
  logic [3:0]  out_nib;
  logic [15:0] out_hold;
  logic        out_last;

  ucode_t     uc;
  logic       step_fire;
  logic       step_end;
  logic [3:0] nib_val;
  logic [15:0] hold_val;
  logic       req_take;
  logic       req_known;
  pc_t        entry_pc;
  logic [7:0] req_byte;
  logic       req_rs;

  assign req.ready  = !busy;
  assign req_take   = req.valid && req.ready;
  assign step_fire  = busy && (!out_valid || pins.ready);

  assign pins.valid      = out_valid;
  assign pins.reg_select = out_rs;
  assign pins.enable_pin = out_en;
  assign pins.bus_nibble = out_nib;
  assign pins.hold_us    = out_hold;
  assign pins.last       = out_last;

  // request decode: byte to send, register select, program entry
  always_comb begin
    req_known = 1'b1;
    entry_pc  = BYTE_ENTRY;
    req_byte  = req.byte_value;
    req_rs    = 1'b0;
    unique case (req.command)
      CMD_INIT:  entry_pc = INIT_ENTRY;
      CMD_INSTR: req_byte = req.byte_value;
      CMD_DATA:  req_rs = 1'b1;
      CMD_GOTO:  req_byte = {DDRAM_SET_MSB[1], req.row, req.column};
      CMD_GLYPH: req_byte = req.glyph_slot[3] ? GLYPH_DONE_BYTE
                                              : {CGRAM_SET_MSB, req.glyph_slot[2:0], 3'b000};
      default:   req_known = 1'b0;
    endcase
  end

  // control word fetch and datapath selects
  assign uc = ucode_rom(pc);

  always_comb begin
    unique case (uc.nib_sel)
      NIB_CONST: nib_val = uc.nib;
      NIB_HI:    nib_val = cur_byte[7:4];
      NIB_LO:    nib_val = cur_byte[3:0];
      default:   nib_val = cur_byte[3:0];
    endcase
  end

  always_comb begin
    unique case (uc.hold_sel)
      HOLD_EN_HIGH:    hold_val = {6'd0, enable_high_us};
      HOLD_EN_GAP:     hold_val = {6'd0, enable_gap_us};
      HOLD_WRITE:      hold_val = write_wait_us;
      HOLD_GOTO:       hold_val = goto_wait_us;
      HOLD_POWER_UP:   hold_val = POWER_UP_US;
      HOLD_WAKE_LONG:  hold_val = WAKE_LONG_US;
      HOLD_WAKE_SHORT: hold_val = WAKE_SHORT_US;
      default:         hold_val = goto_wait_us;
    endcase
  end

  always_comb begin
    unique case (uc.seq)
      SEQ_NEXT:            step_end = 1'b0;
      SEQ_END:             step_end = 1'b1;
      SEQ_END_UNLESS_GOTO: step_end = !is_goto;
      default:             step_end = 1'b1;
    endcase
  end

  // registers, sequencer and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pc             <= INIT_ENTRY;
      out_valid      <= 1'b0;
      enable_high_us <= ENABLE_HIGH_RST;
      enable_gap_us  <= ENABLE_GAP_RST;
      write_wait_us  <= WRITE_WAIT_RST;
      goto_wait_us   <= GOTO_WAIT_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENABLE_HIGH: enable_high_us <= cfg_data[9:0];
          REG_ENABLE_GAP:  enable_gap_us  <= cfg_data[9:0];
          REG_WRITE_WAIT:  write_wait_us  <= cfg_data;
          REG_GOTO_WAIT:   goto_wait_us   <= cfg_data;
          default: ;
        endcase
      end

      if (req_take && req_known) begin
        busy     <= 1'b1;
        pc       <= entry_pc;
        cur_byte <= req_byte;
        cur_rs   <= req_rs;
        is_goto  <= (req.command == CMD_GOTO);
      end

      if (step_fire) begin
        out_valid <= 1'b1;
        out_rs    <= cur_rs;
        out_en    <= uc.en;
        out_nib   <= nib_val;
        out_hold  <= hold_val;
        out_last  <= step_end;
        if (step_end) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end else if (pins.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // step counter stays inside the control store while running
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < PC_W'(ROM_DEPTH)))
    else $error("step counter outside control store");

  // issuing the final control word of a run frees the sequencer
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (step_fire && step_end) |=> (!busy && out_valid && out_last))
    else $error("sequencer still busy after final beat issued");

  // an init request starts at the first control word
  a_init_entry: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.command == CMD_INIT) |=> (busy && pc == INIT_ENTRY))
    else $error("init did not start at program entry");

  // a step only issues when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pins.ready) |=> (out_valid && $stable(out_hold) && $stable(out_nib)))
    else $error("pending beat overwritten");

endmodule
